>>> sv/vpaq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the voice packet admission queue.
// No dependencies; imported by the top, the controller and the checker.
package vpaq_pkg;

    // Fixed field widths
    localparam int HANDLE_W = 8;
    localparam int LEN_W    = 12;
    localparam int TID_W    = 8;
    localparam int LEVEL_W  = 16;
    localparam int THRESH_W = 18;

    // Defaults and limits
    localparam int C_QUEUE_DEPTH     = 64;
    localparam int C_MAX_PACKET_BYTES = 2048;
    localparam logic signed [LEVEL_W-1:0] C_LEVEL_MINUS_INF = 16'sh8000;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_EOT  = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DROP  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // One result beat
    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] head_handle;
        logic [LEN_W-1:0]    head_length;
        logic                not_empty;
        logic                filled;
    } t_result;

endpackage

>>> sv/voice_packet_admission_queue.sv
`timescale 1ns / 1ps
// Voice packet admission queue, top level: threshold register, controller
// and output register. Uses vpaq_pkg, vpaq_ctrl and vpaq_desc_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command beat:
//   enqueue, dequeue, peek head or end of transmission. Every command
//   yields exactly one result beat on the output channel
//   (o_out_valid / i_out_stall).
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the fill
//   threshold; it is always ready. Write it only while the queue is idle.
// Sequencing:
//   The head descriptor read is issued at the accepting edge and the beat
//   is resolved in the following cycle; its result is registered in the
//   output register when it commits, and no new beat is taken until then.
//   The registered read of the descriptor memory sets this sequence.
// Reset:
//   Synchronous, active low. Queue becomes empty, byte total zero, current
//   level minus infinity, threshold zero. Memory contents are not cleared.
// Stall:
//   A stalled result stays in the output register unchanged; the next beat
//   may still be accepted and resolved, then waits until the register frees.
module voice_packet_admission_queue
    import vpaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_mode,
    input  logic [HANDLE_W-1:0]       i_buffer_handle,
    input  logic [LEN_W-1:0]          i_packet_length,
    input  logic [TID_W-1:0]          i_transmission_id,
    input  logic signed [LEVEL_W-1:0] i_signal_level,
    // configuration channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [THRESH_W-1:0]       i_cfg_data,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [HANDLE_W-1:0]       o_head_handle,
    output logic [LEN_W-1:0]          o_head_length,
    output logic                      o_not_empty,
    output logic                      o_filled
);

    logic [THRESH_W-1:0] r_threshold;
    logic                r_out_valid;
    t_result             r_out;
    logic                res_valid;
    logic                res_ready;
    t_result             res;

    // Threshold register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    vpaq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_buffer_handle   (i_buffer_handle),
        .i_packet_length   (i_packet_length),
        .i_transmission_id (i_transmission_id),
        .i_signal_level    (i_signal_level),
        .i_threshold       (r_threshold),
        .o_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .o_res             (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_head_handle = r_out.head_handle;
    assign o_head_length = r_out.head_length;
    assign o_not_empty   = r_out.not_empty;
    assign o_filled      = r_out.filled;

endmodule

>>> sv/vpaq_desc_ram.sv
`timescale 1ns / 1ps
// Descriptor memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module vpaq_desc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/vpaq_ctrl.sv
`timescale 1ns / 1ps
// Queue controller: pointers, count, byte total, admission state and the
// read-modify-write sequence over the descriptor memory. Uses vpaq_pkg.
module vpaq_ctrl
    import vpaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input beats
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic [HANDLE_W-1:0]        i_buffer_handle,
    input  logic [LEN_W-1:0]           i_packet_length,
    input  logic [TID_W-1:0]           i_transmission_id,
    input  logic signed [LEVEL_W-1:0]  i_signal_level,
    // threshold register
    input  logic [THRESH_W-1:0]        i_threshold,
    // result toward the output stage
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output t_result                    o_res
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TOTAL_W = $clog2(QUEUE_DEPTH * C_MAX_PACKET_BYTES + 1);
    localparam int CMP_W   = (TOTAL_W > THRESH_W) ? TOTAL_W : THRESH_W;
    localparam int DATA_W  = HANDLE_W + LEN_W;

    t_state                      r_state, n_state;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [TOTAL_W-1:0]          r_total, n_total;
    logic [TID_W-1:0]            r_cur_tid, n_cur_tid;
    logic signed [LEVEL_W-1:0]   r_cur_level, n_cur_level;

    // latched item
    t_mode                       r_mode;
    logic [HANDLE_W-1:0]         r_handle;
    logic [LEN_W-1:0]            r_len;
    logic [TID_W-1:0]            r_tid;
    logic signed [LEVEL_W-1:0]   r_level;

    logic                        accept;
    logic                        commit;
    logic                        mem_we;
    logic [DATA_W-1:0]           mem_rdata;
    logic [HANDLE_W-1:0]         rd_handle;
    logic [LEN_W-1:0]            rd_len;
    logic [LEN_W-1:0]            sat_len;
    t_result                     res;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign commit     = (r_state == ST_EXEC) && i_res_ready;

    // Saturate oversize packets before they are stored
    assign sat_len = (i_packet_length > LEN_W'(C_MAX_PACKET_BYTES))
                     ? LEN_W'(C_MAX_PACKET_BYTES) : i_packet_length;

    // Descriptor memory: head read issued at accept, tail write at commit
    vpaq_desc_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we && commit),
        .i_waddr (r_tail),
        .i_wdata ({r_handle, r_len}),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign rd_handle = mem_rdata[DATA_W-1:LEN_W];
    assign rd_len    = mem_rdata[LEN_W-1:0];

    // State register and queue bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_cur_tid   <= '0;
            r_cur_level <= C_LEVEL_MINUS_INF;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_total     <= n_total;
                r_cur_tid   <= n_cur_tid;
                r_cur_level <= n_cur_level;
            end
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_handle <= i_buffer_handle;
            r_len    <= sat_len;
            r_tid    <= i_transmission_id;
            r_level  <= i_signal_level;
        end
    end

    // Next state, admission rule and result
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_total     = r_total;
        n_cur_tid   = r_cur_tid;
        n_cur_level = r_cur_level;
        mem_we      = 1'b0;
        res         = '0;
        res.status  = STAT_OK;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        unique case (r_mode)
            MODE_ENQ: begin
                if ((r_count != '0) && (r_tid != r_cur_tid) && (r_level < r_cur_level)) begin
                    res.status      = STAT_DROP;
                    res.head_handle = r_handle;
                end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    res.status      = STAT_FULL;
                    res.head_handle = r_handle;
                end else begin
                    mem_we      = 1'b1;
                    n_cur_tid   = r_tid;
                    n_cur_level = r_level;
                    n_tail      = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count     = r_count + 1'b1;
                    n_total     = r_total + TOTAL_W'(r_len);
                end
            end
            MODE_DEQ, MODE_PEEK: begin
                if (r_count == '0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.head_handle = rd_handle;
                    res.head_length = rd_len;
                    if (r_mode == MODE_DEQ) begin
                        n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_total = r_total - TOTAL_W'(rd_len);
                    end
                end
            end
            MODE_EOT: begin
                if (r_tid == r_cur_tid) begin
                    n_cur_level = C_LEVEL_MINUS_INF;
                end
            end
            default: ;
        endcase

        res.not_empty = (n_count != '0);
        res.filled    = (n_count != '0) && (CMP_W'(n_total) >= CMP_W'(i_threshold));
    end

    assign o_res_valid = (r_state == ST_EXEC);
    assign o_res       = res;

endmodule

>>> sv/vpaq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the voice packet admission queue, bound to the top.
// Uses vpaq_pkg.
module vpaq_checker
    import vpaq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [1:0]                o_status,
    input logic [HANDLE_W-1:0]       o_head_handle,
    input logic [LEN_W-1:0]          o_head_length,
    input logic                      o_not_empty,
    input logic                      o_filled
);

    // A stalled result beat holds its status, descriptor and filled flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_head_handle)
             && $stable(o_head_length) && $stable(o_filled)))
        else $error("stalled result changed");

    // Filled implies the queue is not empty
    a_filled_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_filled) |-> o_not_empty)
        else $error("filled reported on empty queue");

    // Empty status carries no descriptor and an empty queue
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |->
            (!o_not_empty && o_head_handle == '0 && o_head_length == '0))
        else $error("empty status with descriptor or occupancy");

    // Rejected packets report no length and a queue that is not empty
    a_reject_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_DROP || o_status == STAT_FULL)) |->
            (o_head_length == '0 && o_not_empty))
        else $error("rejected packet result malformed");

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind voice_packet_admission_queue vpaq_checker u_vpaq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_head_handle (o_head_handle),
    .o_head_length (o_head_length),
    .o_not_empty   (o_not_empty),
    .o_filled      (o_filled)
);
